### rtl/aescan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescan_pkg
// Types and constants shared by the archive entry scanner modules.
// ----------------------------------------------------------------------------
package aescan_pkg;

    // Entry header magic, in stream order
    localparam logic [7:0] MAGIC0 = 8'h32;
    localparam logic [7:0] MAGIC1 = 8'h44;
    localparam logic [7:0] MAGIC2 = 8'h58;
    localparam logic [7:0] MAGIC3 = 8'h39;

    localparam int unsigned HDR_LEN_BITS = 5;
    localparam logic [HDR_LEN_BITS-1:0] HDR_IDX_AFTER_MAGIC = 5'd4;
    localparam logic [HDR_LEN_BITS-1:0] HDR_IDX_SIZE_FIRST  = 5'd8;
    localparam logic [HDR_LEN_BITS-1:0] HDR_IDX_SIZE_LAST   = 5'd11;
    localparam logic [HDR_LEN_BITS-1:0] HDR_IDX_LAST        = 5'd23;
    localparam logic [31:0]             HDR_LEN             = 32'h0000_0018;

    // Archive offsets of the little-endian entry count
    localparam logic [31:0] CNT_LO_OFS = 32'h0000_0014;
    localparam logic [31:0] CNT_HI_OFS = 32'h0000_0015;

    localparam logic [1:0] RECENT_FULL = 2'd3;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        PH_SCAN   = 2'd0,
        PH_HEADER = 2'd1,
        PH_SKIP   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_archive;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] entry_index;
        logic [31:0] payload_offset;
        logic [31:0] payload_size;
        logic [15:0] entry_count;
        logic        truncated;
    } out_item_t;

    typedef struct packed {
        logic [31:0]             byte_offset;
        logic [23:0]             recent_bytes;
        logic [1:0]              valid_recent;
        phase_t                  phase;
        logic [HDR_LEN_BITS-1:0] header_index;
        logic [31:0]             size_accum;
        logic [31:0]             skip_remaining;
        logic [31:0]             match_start;
        logic [15:0]             found_count;
        logic [15:0]             expected_count;
        logic                    overrun_seen;
    } scan_state_t;

endpackage

### rtl/aescan_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescan_step
// Next scan state and optional result word for one archive byte.
// ----------------------------------------------------------------------------
module aescan_step
(
    input  aescan_pkg::scan_state_t state,
    input  aescan_pkg::in_item_t    item,
    input  logic [31:0]             archive_length,
    output aescan_pkg::scan_state_t state_next,
    output logic                    hit,
    output aescan_pkg::out_item_t   result
);

    aescan_pkg::scan_state_t cur;
    logic [31:0] off;
    logic [7:0]  b;
    logic        magic_hit;
    logic [32:0] start_end;
    logic [33:0] pos_sum;
    logic [33:0] payload_end;
    logic [31:0] size_new;
    logic [31:0] start_pos;

    always_comb
    begin
        cur = state;
        if (item.start_of_archive)
        begin
            cur = '0;
            cur.phase = aescan_pkg::PH_SCAN;
        end
        off = cur.byte_offset;
        b   = item.data_byte;

        state_next = cur;
        hit        = 1'b0;
        result     = '0;

        // Count bytes are captured whatever the phase
        if (off == aescan_pkg::CNT_LO_OFS)
        begin
            state_next.expected_count[7:0] = b;
        end
        if (off == aescan_pkg::CNT_HI_OFS)
        begin
            state_next.expected_count[15:8] = b;
        end

        start_pos = off - 32'd3;
        start_end = {1'b0, start_pos} + {1'b0, aescan_pkg::HDR_LEN};
        magic_hit = (cur.valid_recent == aescan_pkg::RECENT_FULL)
                 && (cur.recent_bytes[23:16] == aescan_pkg::MAGIC0)
                 && (cur.recent_bytes[15:8]  == aescan_pkg::MAGIC1)
                 && (cur.recent_bytes[7:0]   == aescan_pkg::MAGIC2)
                 && (b == aescan_pkg::MAGIC3)
                 && (start_end < {1'b0, archive_length});

        size_new = cur.size_accum;
        if ((cur.header_index >= aescan_pkg::HDR_IDX_SIZE_FIRST)
            && (cur.header_index <= aescan_pkg::HDR_IDX_SIZE_LAST))
        begin
            case (cur.header_index[1:0])
                2'd0:    size_new[7:0]   = b;
                2'd1:    size_new[15:8]  = b;
                2'd2:    size_new[23:16] = b;
                default: size_new[31:24] = b;
            endcase
        end
        pos_sum     = {2'b00, cur.match_start} + {2'b00, aescan_pkg::HDR_LEN};
        payload_end = pos_sum + {2'b00, size_new};

        case (cur.phase)
            aescan_pkg::PH_SCAN:
            begin
                if (magic_hit)
                begin
                    state_next.match_start  = start_pos;
                    state_next.phase        = aescan_pkg::PH_HEADER;
                    state_next.header_index = aescan_pkg::HDR_IDX_AFTER_MAGIC;
                    state_next.size_accum   = '0;
                    state_next.valid_recent = '0;
                    state_next.recent_bytes = '0;
                end
                else
                begin
                    state_next.recent_bytes = {cur.recent_bytes[15:0], b};
                    if (cur.valid_recent != aescan_pkg::RECENT_FULL)
                    begin
                        state_next.valid_recent = cur.valid_recent + 2'd1;
                    end
                end
            end
            aescan_pkg::PH_HEADER:
            begin
                state_next.size_accum = size_new;
                if (cur.header_index >= aescan_pkg::HDR_IDX_LAST)
                begin
                    state_next.header_index = '0;
                    if (cur.found_count >= state_next.expected_count)
                    begin
                        state_next.phase = aescan_pkg::PH_DONE;
                    end
                    else if (payload_end > {2'b00, archive_length})
                    begin
                        state_next.overrun_seen = 1'b1;
                        state_next.phase        = aescan_pkg::PH_DONE;
                    end
                    else
                    begin
                        hit                   = 1'b1;
                        result.kind           = aescan_pkg::KIND_ENTRY;
                        result.entry_index    = cur.found_count;
                        result.payload_offset = pos_sum[31:0];
                        result.payload_size   = size_new;
                        state_next.found_count    = cur.found_count + 16'd1;
                        state_next.skip_remaining = size_new;
                        state_next.phase = (size_new == '0) ? aescan_pkg::PH_SCAN
                                                            : aescan_pkg::PH_SKIP;
                    end
                end
                else
                begin
                    state_next.header_index = cur.header_index + 5'd1;
                end
            end
            aescan_pkg::PH_SKIP:
            begin
                if (cur.skip_remaining <= 32'd1)
                begin
                    state_next.skip_remaining = '0;
                    state_next.phase          = aescan_pkg::PH_SCAN;
                end
                else
                begin
                    state_next.skip_remaining = cur.skip_remaining - 32'd1;
                end
            end
            default:
            begin
                state_next.phase = aescan_pkg::PH_DONE;
            end
        endcase

        // Summary on the last archive byte, unless an entry goes out there
        if (!hit && (archive_length != '0) && (off == archive_length - 32'd1))
        begin
            hit                = 1'b1;
            result             = '0;
            result.kind        = aescan_pkg::KIND_SUMMARY;
            result.entry_count = state_next.found_count;
            result.truncated   = state_next.overrun_seen;
        end

        state_next.byte_offset = off + 32'd1;
    end

endmodule

### rtl/archive_entry_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_entry_scanner_top
// Byte-serial scanner that finds entry headers in an audio archive and
// reports each entry's payload offset and size, plus an end-of-archive summary.
// ----------------------------------------------------------------------------
//
//  channel   signals                              direction  word
//  -------   -----------------------------------  ---------  ----------------
//  item      item_valid, item_stall, item         in         in_item_t
//  result    result_valid, result_stall, result   out        out_item_t
//  length    length_we, length_wdata              in         32-bit length
//
//  Rate: one archive byte per clock while item_stall is low; a result word,
//  when a byte causes one, is loaded into the output register at the edge
//  that takes the byte, since the step is combinational and the scan state
//  and the output register both update at that edge.
//  Reset: rst_n clears the scan state, the length register and the output
//  valid flag at once; no clearing pass follows.
//  Stalls: item_stall rises only while a result word is held and the
//  downstream side stalls it; while the output drains, bytes keep flowing.
//
module archive_entry_scanner_top
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  aescan_pkg::in_item_t  item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output aescan_pkg::out_item_t result,
    input  logic                  length_we,
    input  logic [31:0]           length_wdata
);

    // Archive length register (to be written only while idle; the block does not enforce this)
    logic [31:0] length_reg;

    // Scan state, updated once per accepted byte
    aescan_pkg::scan_state_t state_reg;
    aescan_pkg::scan_state_t state_next;

    // Output register: holds a finished word until downstream takes it
    logic                  result_valid_reg;
    logic                  result_valid_next;
    aescan_pkg::out_item_t result_reg;
    aescan_pkg::out_item_t result_next;

    logic                  step_hit;
    aescan_pkg::out_item_t step_result;
    aescan_pkg::scan_state_t step_state;
    logic                  item_take;

    // Hold input only when the output register is full and stalled
    assign item_stall = result_valid_reg && result_stall;
    assign item_take  = item_valid && !item_stall;

    aescan_step u_step
    (
        .state          (state_reg),
        .item           (item),
        .archive_length (length_reg),
        .state_next     (step_state),
        .hit            (step_hit),
        .result         (step_result)
    );

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (item_take)
        begin
            // Advance the scan; load the output register (or drop it empty)
            state_next        = step_state;
            result_valid_next = step_hit;
            result_next       = step_result;
        end
        else if (!result_stall)
        begin
            // Word taken downstream with nothing new behind it
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg       <= '0;
            state_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (length_we)
            begin
                length_reg <= length_wdata;
            end
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Header index stays within the header while a header is being read
    a_hdr_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == aescan_pkg::PH_HEADER) |->
            ((state_reg.header_index >= aescan_pkg::HDR_IDX_AFTER_MAGIC)
             && (state_reg.header_index <= aescan_pkg::HDR_IDX_LAST)))
        else $error("header index out of range");

    // Header index is parked at zero outside the header phase
    a_hdr_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != aescan_pkg::PH_HEADER) |->
            (state_reg.header_index == '0))
        else $error("header index not cleared outside header");

    // Skip phase always has payload left to skip
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == aescan_pkg::PH_SKIP) |->
            (state_reg.skip_remaining != '0))
        else $error("skip phase with nothing to skip");

    // An accepted byte advances the offset by exactly one, or restarts it
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && !item.start_of_archive) |=>
            (state_reg.byte_offset == $past(state_reg.byte_offset) + 32'd1))
        else $error("byte offset did not advance by one");

    // Input is held off only while an output word sits stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without a pending output word");

endmodule
